FILE: hw/rtl/three_axis_pid_controller_defines.svh
// ----------------------------------------------------------------------------
// three-axis pid controller assertion macros
// shared concurrent assertion forms for the controller and its divider
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_PID_CONTROLLER_DEFINES_SVH
`define THREE_AXIS_PID_CONTROLLER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TAPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tapc same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TAPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tapc next-cycle check failed");

`endif

FILE: hw/rtl/tapc_pkg.sv
// ----------------------------------------------------------------------------
// tapc_pkg
// shared types and constants of the three-axis pid controller
// ----------------------------------------------------------------------------
package tapc_pkg;

    // operations of an input item
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // axis codes
    localparam logic [1:0] AXIS_ROLL    = 2'd0;
    localparam logic [1:0] AXIS_PITCH   = 2'd1;
    localparam logic [1:0] AXIS_YAW     = 2'd2;
    localparam logic [1:0] AXIS_INVALID = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ROLL_GAINS  = 2'd0;
    localparam logic [1:0] CFG_PITCH_GAINS = 2'd1;
    localparam logic [1:0] CFG_YAW_GAINS   = 2'd2;
    localparam logic [1:0] CFG_INT_LIMIT   = 2'd3;

    // reset values of the configuration registers
    localparam logic [47:0] RST_ROLL_GAINS  = 48'd1760950032384;
    localparam logic [47:0] RST_PITCH_GAINS = 48'd1760950032384;
    localparam logic [47:0] RST_YAW_GAINS   = 48'd1760941973504;
    localparam logic [30:0] RST_INT_LIMIT   = 31'd3276800;

    // saturation bounds of a signed 32-bit value
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // divider dividend width: sign-free |diff| (33) plus 16 fraction bits, padded even
    localparam int DIV_NUM_W = 50;
    localparam logic [4:0] DIV_STEPS = 5'd25;

    // request to the derivative divider
    typedef struct packed {
        logic               start;
        logic signed [32:0] diff;
        logic [15:0]        den;
    } t_div_req;

    // answer of the derivative divider
    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } t_div_rsp;

endpackage

FILE: hw/rtl/tapc_div.sv
// ----------------------------------------------------------------------------
// tapc_div
// iterative radix-2 divider, two quotient bits per cycle, forms the
// saturated derivative (diff * 65536) / den truncated toward zero
// ----------------------------------------------------------------------------
`include "three_axis_pid_controller_defines.svh"

module tapc_div
    import tapc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [4:0]           r_cnt;
    logic                 r_done;
    logic                 r_neg;
    logic [DIV_NUM_W-1:0] r_num;
    logic [15:0]          r_rem;
    logic [15:0]          r_den;

    logic [32:0] w_mag;
    logic [16:0] w_t1;
    logic [16:0] w_t2;
    logic        w_ge1;
    logic        w_ge2;
    logic [15:0] w_rem1;
    logic [15:0] w_rem2;
    logic        w_pos_ovf;
    logic        w_neg_ovf;

    // magnitude of the error change
    assign w_mag = i_req.diff[32] ? (33'd0 - i_req.diff) : i_req.diff;

    // two restoring compare-subtract steps
    always_comb begin
        w_t1   = {r_rem, r_num[DIV_NUM_W-1]};
        w_ge1  = (w_t1 >= {1'b0, r_den});
        w_rem1 = w_ge1 ? 16'(w_t1 - {1'b0, r_den}) : w_t1[15:0];
        w_t2   = {w_rem1, r_num[DIV_NUM_W-2]};
        w_ge2  = (w_t2 >= {1'b0, r_den});
        w_rem2 = w_ge2 ? 16'(w_t2 - {1'b0, r_den}) : w_t2[15:0];
    end

    // iteration sequencer; quotient bits shift in at the bottom of r_num
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 5'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= DIV_STEPS;
            end else if (r_cnt != 5'd0) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.diff[32];
            r_num <= {1'b0, w_mag, 16'd0};
            r_rem <= 16'd0;
            r_den <= i_req.den;
        end else if (r_cnt != 5'd0) begin
            r_num <= {r_num[DIV_NUM_W-3:0], w_ge1, w_ge2};
            r_rem <= w_rem2;
        end
    end

    // sign and saturate the quotient magnitude
    assign w_pos_ovf = |r_num[DIV_NUM_W-1:31];
    assign w_neg_ovf = (|r_num[DIV_NUM_W-1:32]) || (r_num[31] && (|r_num[30:0]));

    always_comb begin
        o_rsp.done = r_done;
        if (r_neg) begin
            o_rsp.quot = w_neg_ovf ? S32_MIN : $signed(32'd0 - r_num[31:0]);
        end else begin
            o_rsp.quot = w_pos_ovf ? S32_MAX : $signed(r_num[31:0]);
        end
    end

    // partial remainder stays below the divisor while iterating
    `TAPC_ASSERT_SAME(a_rem_below_den, i_clk, i_rst_n, r_cnt != 5'd0, r_rem < r_den)
    // a division is never started with a zero divisor
    `TAPC_ASSERT_SAME(a_den_nonzero, i_clk, i_rst_n, i_req.start, i_req.den != 16'd0)
    // done follows the last iteration
    `TAPC_ASSERT_NEXT(a_done_after_last, i_clk, i_rst_n, r_cnt == 5'd1 && !i_req.start, r_done)

endmodule

FILE: hw/rtl/three_axis_pid_controller.sv
// ----------------------------------------------------------------------------
// three_axis_pid_controller: roll, pitch and yaw pid loops in signed q16.16
// one item in flight: input is taken only in idle, after the previous result is loaded
// a step goes through error, integral, divider wait, gain products and accumulate;
// with a zero time step the divider is not started and the derivative is zero
// clear items stay in idle; sync active-low reset zeroes integrals and restores gains
// ----------------------------------------------------------------------------
`include "three_axis_pid_controller_defines.svh"

module three_axis_pid_controller
    import tapc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration writes
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [1:0]         i_axis,
    input  logic signed [31:0] i_measured,
    input  logic signed [31:0] i_target,
    input  logic [15:0]        i_time_step,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_result_axis,
    output logic signed [31:0] o_drive
);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ERR    = 4'd1;
    localparam logic [3:0] S_INT    = 4'd2;
    localparam logic [3:0] S_INTADD = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_MP     = 4'd5;
    localparam logic [3:0] S_MI     = 4'd6;
    localparam logic [3:0] S_MD     = 4'd7;
    localparam logic [3:0] S_ACC    = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic [1:0]         r_axis;
    logic signed [31:0] r_meas;
    logic signed [31:0] r_targ;
    logic [15:0]        r_dt;
    logic signed [31:0] r_err;
    logic signed [31:0] r_integ;
    logic signed [31:0] r_deriv;
    logic signed [48:0] r_prod;
    logic signed [49:0] r_acc;
    logic               r_out_valid;
    logic [1:0]         r_out_axis;
    logic signed [31:0] r_out_drive;
    logic [47:0]        r_gains [3];
    logic [30:0]        r_limit;
    logic signed [31:0] r_integral [3];
    logic signed [31:0] r_last_err [3];

    logic               w_in_xfer;
    logic               w_out_load;
    logic [47:0]        w_gain;
    logic signed [32:0] w_err_raw;
    logic signed [31:0] w_err_sat;
    logic signed [33:0] w_int_sum;
    logic signed [33:0] w_lim_pos;
    logic signed [33:0] w_lim_neg;
    logic signed [31:0] w_int_clamp;
    logic signed [31:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [37:0] w_shifted;
    logic signed [31:0] w_drive_sat;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    assign o_ready       = (r_state == S_IDLE);
    assign w_in_xfer     = i_valid && o_ready;
    assign w_out_load    = (r_state == S_DONE) && (!r_out_valid || i_ready);
    assign o_valid       = r_out_valid;
    assign o_result_axis = r_out_axis;
    assign o_drive       = r_out_drive;

    // gains of the active axis
    always_comb begin
        case (r_axis)
            AXIS_ROLL:  w_gain = r_gains[0];
            AXIS_PITCH: w_gain = r_gains[1];
            AXIS_YAW:   w_gain = r_gains[2];
            default:    w_gain = 48'd0;
        endcase
    end

    // saturated error
    always_comb begin
        w_err_raw = {r_targ[31], r_targ} - {r_meas[31], r_meas};
        if (w_err_raw[32] != w_err_raw[31]) begin
            w_err_sat = w_err_raw[32] ? S32_MIN : S32_MAX;
        end else begin
            w_err_sat = w_err_raw[31:0];
        end
    end

    // integral update with floor shift of the increment and clamp
    always_comb begin
        w_int_sum = {{2{r_integral[r_axis][31]}}, r_integral[r_axis]}
                  + {r_prod[48], r_prod[48:16]};
        w_lim_pos = {3'b000, r_limit};
        w_lim_neg = 34'sd0 - w_lim_pos;
        if (w_int_sum > w_lim_pos) begin
            w_int_clamp = w_lim_pos[31:0];
        end else if (w_int_sum < w_lim_neg) begin
            w_int_clamp = w_lim_neg[31:0];
        end else begin
            w_int_clamp = w_int_sum[31:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_INT: begin
                w_mul_a = r_err;
                w_mul_b = $signed({1'b0, r_dt});
            end
            S_MP: begin
                w_mul_a = r_err;
                w_mul_b = $signed({w_gain[15], w_gain[15:0]});
            end
            S_MI: begin
                w_mul_a = r_integ;
                w_mul_b = $signed({w_gain[31], w_gain[31:16]});
            end
            S_MD: begin
                w_mul_a = r_deriv;
                w_mul_b = $signed({w_gain[47], w_gain[47:32]});
            end
            default: begin
                w_mul_a = r_err;
                w_mul_b = 17'sd0;
            end
        endcase
    end

    // drive: floor shift by 12 and saturate
    always_comb begin
        w_shifted = r_acc[49:12];
        if (!w_shifted[37] && (|w_shifted[36:31])) begin
            w_drive_sat = S32_MAX;
        end else if (w_shifted[37] && !(&w_shifted[36:31])) begin
            w_drive_sat = S32_MIN;
        end else begin
            w_drive_sat = w_shifted[31:0];
        end
    end

    // divider request, issued once the error is known
    always_comb begin
        w_div_req.start = (r_state == S_INT) && (r_dt != 16'd0);
        w_div_req.diff  = {r_err[31], r_err} - {r_last_err[r_axis][31], r_last_err[r_axis]};
        w_div_req.den   = r_dt;
    end

    tapc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer && i_op == OP_STEP && i_axis != AXIS_INVALID) begin
                    n_state = S_ERR;
                end
            end
            S_ERR:    n_state = S_INT;
            S_INT:    n_state = S_INTADD;
            S_INTADD: n_state = S_DIV;
            S_DIV: begin
                if (r_dt == 16'd0 || w_div_rsp.done) begin
                    n_state = S_MP;
                end
            end
            S_MP:     n_state = S_MI;
            S_MI:     n_state = S_MD;
            S_MD:     n_state = S_ACC;
            S_ACC:    n_state = S_DONE;
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control state, configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_gains[0]  <= RST_ROLL_GAINS;
            r_gains[1]  <= RST_PITCH_GAINS;
            r_gains[2]  <= RST_YAW_GAINS;
            r_limit     <= RST_INT_LIMIT;
            for (int i = 0; i < 3; i++) begin
                r_integral[i] <= 32'sd0;
                r_last_err[i] <= 32'sd0;
            end
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROLL_GAINS:  r_gains[0] <= i_cfg_data;
                    CFG_PITCH_GAINS: r_gains[1] <= i_cfg_data;
                    CFG_YAW_GAINS:   r_gains[2] <= i_cfg_data;
                    CFG_INT_LIMIT:   r_limit    <= i_cfg_data[30:0];
                    default:         r_limit    <= r_limit;
                endcase
            end

            // clear item zeroes every integral
            if (w_in_xfer && i_op == OP_CLEAR) begin
                for (int i = 0; i < 3; i++) begin
                    r_integral[i] <= 32'sd0;
                end
            end

            if (r_state == S_INT) begin
                r_last_err[r_axis] <= r_err;
            end
            if (r_state == S_INTADD) begin
                r_integral[r_axis] <= w_int_clamp;
            end

            // result register
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        if (w_in_xfer) begin
            r_axis <= i_axis;
            r_meas <= i_measured;
            r_targ <= i_target;
            r_dt   <= i_time_step;
        end
        case (r_state)
            S_ERR:    r_err   <= w_err_sat;
            S_INTADD: r_integ <= w_int_clamp;
            S_DIV:    r_deriv <= (r_dt == 16'd0) ? 32'sd0 : w_div_rsp.quot;
            S_MI:     r_acc   <= {r_prod[48], r_prod};
            S_MD:     r_acc   <= r_acc + {r_prod[48], r_prod};
            S_ACC:    r_acc   <= r_acc + {r_prod[48], r_prod};
            default:  r_acc   <= r_acc;
        endcase
        if (w_out_load) begin
            r_out_axis  <= r_axis;
            r_out_drive <= w_drive_sat;
        end
    end

    // integral used for the drive is within the clamp
    `TAPC_ASSERT_SAME(a_integ_clamped, i_clk, i_rst_n, r_state == S_MI, r_integ <= $signed({1'b0, r_limit}) && r_integ >= -$signed({1'b0, r_limit}))
    // divider completes only while the sequencer waits for it
    `TAPC_ASSERT_SAME(a_div_done_in_wait, i_clk, i_rst_n, w_div_rsp.done, r_state == S_DIV)
    // finishing an item always presents a result
    `TAPC_ASSERT_NEXT(a_done_gives_result, i_clk, i_rst_n, w_out_load, r_out_valid && r_state == S_IDLE)
    // a clear transfer leaves every integral at zero
    `TAPC_ASSERT_NEXT(a_clear_zeroes, i_clk, i_rst_n, w_in_xfer && i_op == OP_CLEAR, r_integral[0] == 32'sd0 && r_integral[1] == 32'sd0 && r_integral[2] == 32'sd0)

endmodule
